// ===== rtl/fsa_pkg.sv =====
`default_nettype none

package fsa_pkg;

  // Number of slots in the map; must be a multiple of CELL_W.
  localparam int SLOTS     = 64;
  // Slots held by one cell of the chain.
  localparam int CELL_W    = 8;
  localparam int NUM_CELLS = SLOTS / CELL_W;
  // Internal slot number, wide enough to hold SLOTS itself ("none").
  localparam int POS_W     = $clog2(SLOTS + 1);

  // Fixed field widths of the request and response.
  localparam int MODE_W  = 3;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;
  localparam int SLOT_W  = 7;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_TAKE          = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TAKE_BELOW    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RESERVE_ONE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RESERVE_RANGE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TAKE_RUN      = 3'd4;
  localparam logic [MODE_W-1:0] MODE_QUERY         = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] index;
    logic [INDEX_W-1:0] last_index;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] limit;
  } fsa_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              found;
  } fsa_rsp_t;

  // Token that sweeps down the chain, one cell per cycle.
  // clear = 0: search for the first run of len free slots.
  // clear = 1: take every slot in lo..hi, hit reports that one was free.
  typedef struct packed {
    logic             valid;
    logic             clear;
    logic [POS_W-1:0] len;
    logic [POS_W-1:0] run;
    logic             hit;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
  } fsa_wave_t;

endpackage

`default_nettype wire

// ===== rtl/fsa_cell.sv =====
`default_nettype none

module fsa_cell (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [fsa_pkg::POS_W-1:0] base_i,
  input  wire fsa_pkg::fsa_wave_t        wave_i,
  output fsa_pkg::fsa_wave_t             wave_o
);
  import fsa_pkg::*;

  logic [CELL_W-1:0] map_q, map_d;
  fsa_wave_t         wave_q, wave_d;

  always_comb begin
    fsa_wave_t         w;
    logic [CELL_W-1:0] m;
    logic [POS_W-1:0]  p;
    w = wave_i;
    m = map_q;
    p = base_i;
    for (int j = 0; j < CELL_W; j++) begin
      p = base_i + POS_W'(j);
      if (w.valid) begin
        if (w.clear) begin
          if (p >= w.lo && p <= w.hi) begin
            if (m[j]) begin
              w.hit = 1'b1;
            end
            m[j] = 1'b0;
          end
        end else if (!w.hit) begin
          w.run = m[j] ? w.run + POS_W'(1) : '0;
          if (w.run == w.len) begin
            w.hit = 1'b1;
            w.pos = p + POS_W'(1) - w.len;
          end
        end
      end
    end
    map_d  = m;
    wave_d = w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q  <= '1;
      wave_q <= '0;
    end else begin
      map_q  <= map_d;
      wave_q <= wave_d;
    end
  end

  assign wave_o = wave_q;

endmodule

`default_nettype wire

// ===== rtl/free_slot_allocator_top.sv =====
// Free slot allocator: first-fit allocation over a bitmap of free slots.
//
// Request channel: a request (req_i) is taken on a rising edge with start_i
// high and busy_o low. Response channel: rsp_o is valid for exactly one
// cycle while rsp_valid_o is high; the receiver cannot stall it. The next
// request may be taken in the same cycle that a response is shown.
//
// The map lives in a chain of NUM_CELLS cells, CELL_W slots each. Each map
// pass is a token that moves one cell per cycle down the chain: a
// search pass finds the first run of free slots, a clear pass takes a range.
// Requests that need no pass (run of zero, too-long run, empty range, unused
// mode) are answered straight from the idle state. A query and a failed take
// answer after one search pass; reserve one and reserve range after one clear
// pass; a successful take (lowest, below limit, run) after a search pass and
// then a clear pass. The chain length sets how long a pass lasts; one request
// is in flight at a time.
// After reset every slot is free and no response is pending.

`default_nettype none

module free_slot_allocator_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire fsa_pkg::fsa_req_t req_i,
  output logic                   busy_o,
  output logic                   rsp_valid_o,
  output fsa_pkg::fsa_rsp_t      rsp_o
);
  import fsa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CLEAR
  } state_e;

  state_e           state_q, state_d;
  fsa_req_t         req_q, req_d;
  logic [POS_W-1:0] len_q, len_d;
  fsa_wave_t        head_q, head_d;
  logic             rsp_valid_q, rsp_valid_d;
  fsa_rsp_t         rsp_q, rsp_d;
  // Take found from the clear pass (reserve one) rather than holding it.
  logic             use_hit_q, use_hit_d;

  fsa_wave_t chain [NUM_CELLS+1];
  fsa_wave_t tail;

  assign chain[0] = head_q;
  assign tail     = chain[NUM_CELLS];

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_chain
    fsa_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .base_i (POS_W'(i * CELL_W)),
      .wave_i (chain[i]),
      .wave_o (chain[i+1])
    );
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    len_d       = len_q;
    head_d      = '0;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    use_hit_d   = use_hit_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          req_d = req_i;
          unique case (req_i.mode) inside
            MODE_TAKE, MODE_TAKE_BELOW, MODE_QUERY: begin
              // Lowest free slot is the first run of length one.
              len_d        = POS_W'(1);
              head_d.valid = 1'b1;
              head_d.len   = POS_W'(1);
              state_d      = ST_SEARCH;
            end
            MODE_TAKE_RUN: begin
              if (req_i.count == '0) begin
                rsp_d       = '{slot: '0, found: 1'b1};
                rsp_valid_d = 1'b1;
              end else if (32'(req_i.count) > SLOTS) begin
                rsp_d       = '{slot: SLOT_W'(SLOTS), found: 1'b0};
                rsp_valid_d = 1'b1;
              end else begin
                len_d        = POS_W'(req_i.count);
                head_d.valid = 1'b1;
                head_d.len   = POS_W'(req_i.count);
                state_d      = ST_SEARCH;
              end
            end
            MODE_RESERVE_ONE: begin
              head_d.valid = 1'b1;
              head_d.clear = 1'b1;
              head_d.lo    = POS_W'(req_i.index);
              head_d.hi    = POS_W'(req_i.index);
              rsp_d        = '{slot: SLOT_W'(req_i.index), found: 1'b0};
              use_hit_d    = 1'b1;
              state_d      = ST_CLEAR;
            end
            MODE_RESERVE_RANGE: begin
              if (req_i.last_index >= req_i.index) begin
                head_d.valid = 1'b1;
                head_d.clear = 1'b1;
                head_d.lo    = POS_W'(req_i.index);
                head_d.hi    = POS_W'(req_i.last_index);
                rsp_d        = '{slot: SLOT_W'(req_i.index), found: 1'b1};
                use_hit_d    = 1'b0;
                state_d      = ST_CLEAR;
              end else begin
                // Empty range: nothing to take.
                rsp_d       = '{slot: SLOT_W'(req_i.index), found: 1'b0};
                rsp_valid_d = 1'b1;
              end
            end
            default: begin
              rsp_d       = '{slot: SLOT_W'(SLOTS), found: 1'b0};
              rsp_valid_d = 1'b1;
            end
          endcase
        end
      end

      ST_SEARCH: begin
        if (tail.valid) begin
          if (tail.hit && req_q.mode == MODE_QUERY) begin
            rsp_d       = '{slot: SLOT_W'(tail.pos), found: 1'b1};
            rsp_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end else if (tail.hit && (req_q.mode != MODE_TAKE_BELOW ||
                                    32'(tail.pos) < 32'(req_q.limit))) begin
            // Launch the clear pass over the run that was found.
            head_d.valid = 1'b1;
            head_d.clear = 1'b1;
            head_d.lo    = tail.pos;
            head_d.hi    = tail.pos + len_q - POS_W'(1);
            rsp_d        = '{slot: SLOT_W'(tail.pos), found: 1'b1};
            use_hit_d    = 1'b0;
            state_d      = ST_CLEAR;
          end else begin
            rsp_d       = '{slot: SLOT_W'(SLOTS), found: 1'b0};
            rsp_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end
        end
      end

      ST_CLEAR: begin
        if (tail.valid) begin
          if (use_hit_q) begin
            rsp_d.found = tail.hit;
          end
          rsp_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      rsp_valid_q <= 1'b0;
      use_hit_q   <= 1'b0;
      req_q       <= '0;
      len_q       <= '0;
      rsp_q       <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      rsp_valid_q <= rsp_valid_d;
      use_hit_q   <= use_hit_d;
      req_q       <= req_d;
      len_q       <= len_d;
      rsp_q       <= rsp_d;
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/fsa_checker.sv =====
`default_nettype none

module fsa_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start_i,
  input wire fsa_pkg::fsa_req_t req_i,
  input wire logic              busy_o,
  input wire logic              rsp_valid_o,
  input wire fsa_pkg::fsa_rsp_t rsp_o
);
  import fsa_pkg::*;

  // A run of zero answers on the next cycle with slot zero.
  a_zero_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_i.mode == MODE_TAKE_RUN && req_i.count == '0) |=>
    (rsp_valid_o && rsp_o.found && rsp_o.slot == '0))
    else $error("zero run not answered at once");

  // An accepted request either answers at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || rsp_valid_o))
    else $error("accepted request dropped");

  // No response without a request in flight.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_o && !start_i) |=> !rsp_valid_o)
    else $error("response without request");

  // A successful response names a real slot.
  a_found_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.found) |-> (32'(rsp_o.slot) < SLOTS))
    else $error("found response with out-of-range slot");

  // Entering a multi-cycle request does not coincide with a response.
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> !rsp_valid_o)
    else $error("response while starting a pass");

endmodule

bind free_slot_allocator_top fsa_checker u_fsa_checker (.*);

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import fsa_pkg::*;

  // Mode codes the block does not define; they must give no slot and change nothing.
  localparam logic [MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

  // Longest request in flight is a successful take: a search sweep and then a clear sweep of the chain.
  localparam int SETTLE_CYCLES = 2 * NUM_CELLS + 6;
  localparam int MAX_REPORTS   = 10;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     start     = 1'b0;
  fsa_req_t req       = '0;
  logic     busy;
  logic     rsp_valid;
  fsa_rsp_t rsp;

  // Predictor state: one bit per slot, 1 = free.
  logic [SLOTS-1:0] free_map = '1;
  // Responses still owed by the block, oldest first.
  fsa_rsp_t         owed_rsp[$];
  int               error_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  free_slot_allocator_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .req_i       (req),
    .busy_o      (busy),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int lowest_free_slot();
    for (int s = 0; s < SLOTS; s++) begin
      if (free_map[s]) return s;
    end
    return SLOTS;
  endfunction

  // Work out the response to one accepted request and apply it to the map.
  function automatic fsa_rsp_t predict_allocation(fsa_req_t r);
    fsa_rsp_t res;
    int       s;
    int       run;
    int       len;
    res.slot  = SLOT_W'(SLOTS);
    res.found = 1'b0;
    case (r.mode)
      MODE_TAKE, MODE_TAKE_BELOW, MODE_QUERY: begin
        s = lowest_free_slot();
        if (s < SLOTS && (r.mode != MODE_TAKE_BELOW || s < int'(r.limit))) begin
          res.slot  = SLOT_W'(s);
          res.found = 1'b1;
          if (r.mode != MODE_QUERY) free_map[s] = 1'b0;
        end
      end
      MODE_RESERVE_ONE: begin
        res.slot = SLOT_W'(r.index);
        if (free_map[r.index]) begin
          free_map[r.index] = 1'b0;
          res.found         = 1'b1;
        end
      end
      MODE_RESERVE_RANGE: begin
        res.slot = SLOT_W'(r.index);
        if (r.last_index >= r.index) begin
          for (int k = int'(r.index); k <= int'(r.last_index); k++) free_map[k] = 1'b0;
          res.found = 1'b1;
        end
      end
      MODE_TAKE_RUN: begin
        len = int'(r.count);
        if (len == 0) begin
          res.slot  = '0;
          res.found = 1'b1;
        end else if (len <= SLOTS) begin
          // First fit: stop at the first slot that closes a run of len free slots.
          run = 0;
          for (s = 0; s < SLOTS; s++) begin
            run = free_map[s] ? run + 1 : 0;
            if (run == len) break;
          end
          if (s < SLOTS) begin
            s = s + 1 - len;
            for (int k = 0; k < len; k++) free_map[s + k] = 1'b0;
            res.slot  = SLOT_W'(s);
            res.found = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Response checker: pop the oldest owed response, then log a newly accepted
  // request. Popping first keeps order right when both land on one edge.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    fsa_rsp_t want;
    if (rst_n) begin
      if (rsp_valid) begin
        if (owed_rsp.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: response with none owed: slot %0d found %0b",
                     $time, rsp.slot, rsp.found);
        end else begin
          want = owed_rsp.pop_front();
          if (rsp.slot !== want.slot || rsp.found !== want.found) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("%0t: mismatch: slot exp %0d got %0d, found exp %0b got %0b",
                       $time, want.slot, rsp.slot, want.found, rsp.found);
          end
        end
      end
      if (start && !busy) owed_rsp.push_back(predict_allocation(req));
    end
  end

  // ---------------------------------------------------------------------------
  // Request generation
  // ---------------------------------------------------------------------------

  function automatic fsa_req_t make_req(logic [MODE_W-1:0] m, int idx, int last, int cnt,
                                        int lim);
    fsa_req_t r;
    r.mode       = m;
    r.index      = INDEX_W'(idx);
    r.last_index = INDEX_W'(last);
    r.count      = COUNT_W'(cnt);
    r.limit      = COUNT_W'(lim);
    return r;
  endfunction

  // Slots are never freed, so keep takes rare: most requests probe the map
  // without changing it, a few eat slots, a few are raw noise.
  function automatic fsa_req_t random_request();
    fsa_req_t    r;
    logic [31:0] bits;
    int          low;
    int          best;
    int          run;
    int          pick;
    bits = $urandom;
    r    = bits[$bits(fsa_req_t)-1:0];
    low  = lowest_free_slot();
    pick = $urandom_range(0, 99);
    if (pick < 2) return r;
    if (pick < 6) begin
      case ($urandom_range(0, 4))
        0: r.mode = MODE_TAKE;
        1: begin
          r.mode  = MODE_TAKE_BELOW;
          r.limit = COUNT_W'($urandom_range(low + 1, 127));
        end
        2: r.mode = MODE_RESERVE_ONE;
        3: begin
          r.mode       = MODE_RESERVE_RANGE;
          r.last_index = (r.index > 59) ? INDEX_W'(63) : r.index + INDEX_W'($urandom_range(0, 3));
        end
        default: begin
          r.mode  = MODE_TAKE_RUN;
          r.count = COUNT_W'($urandom_range(1, 6));
        end
      endcase
      return r;
    end
    case ($urandom_range(0, 6))
      0: r.mode = MODE_QUERY;
      1: begin
        // Limit at or under the lowest free slot: the take must fail.
        r.mode  = MODE_TAKE_BELOW;
        r.limit = COUNT_W'($urandom_range(0, low));
      end
      2: begin
        // Aim at a slot already taken where one can be found quickly.
        r.mode = MODE_RESERVE_ONE;
        for (int i = 0; i < 8 && free_map[r.index]; i++) r.index = INDEX_W'($urandom);
      end
      3: begin
        r.mode       = MODE_RESERVE_RANGE;
        r.index      = INDEX_W'($urandom_range(1, 63));
        r.last_index = INDEX_W'($urandom_range(0, r.index - 1));
      end
      4: begin
        r.mode  = MODE_TAKE_RUN;
        r.count = $urandom_range(0, 1) ? '0 : COUNT_W'($urandom_range(SLOTS + 1, 127));
      end
      5: begin
        // Longer than the longest free run: the search must sweep and miss.
        best = 0;
        run  = 0;
        for (int s = 0; s < SLOTS; s++) begin
          run  = free_map[s] ? run + 1 : 0;
          best = (run > best) ? run : best;
        end
        if (best >= SLOTS) begin
          r.mode = MODE_QUERY;
        end else begin
          r.mode  = MODE_TAKE_RUN;
          r.count = COUNT_W'($urandom_range(best + 1, SLOTS));
        end
      end
      default: r.mode = $urandom_range(0, 1) ? MODE_UNUSED_6 : MODE_UNUSED_7;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Present one request and hold it until the block takes it. Start stays
  // high on return so back-to-back requests need no extra edge.
  task automatic issue_request(input fsa_req_t r);
    req   <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start and drive junk on the request bus, which must be ignored.
  task automatic hold_off(input int n);
    start <= 1'b0;
    req   <= random_request();
    repeat (n) @(posedge clk);
  endtask

  // Stop sending and wait until every owed response has come back.
  task automatic wait_all_done();
    start <= 1'b0;
    @(posedge clk);
    while (owed_rsp.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Walk every mode and the field extremes from a fresh map, building a
  // fragmented map whose runs cross cell boundaries.
  task automatic test_directed_modes();
    issue_request(make_req(MODE_QUERY,         0,  0,   0,   0));
    issue_request(make_req(MODE_TAKE,          0,  0,   0,   0));
    issue_request(make_req(MODE_TAKE_BELOW,    0,  0,   0,   0));    // limit zero
    issue_request(make_req(MODE_TAKE_BELOW,    0,  0,   0,   2));
    issue_request(make_req(MODE_TAKE_BELOW,   63, 63, 127, 127));
    issue_request(make_req(MODE_RESERVE_ONE,  63,  0,   0,   0));
    issue_request(make_req(MODE_RESERVE_ONE,  63,  0,   0,   0));    // already taken
    issue_request(make_req(MODE_RESERVE_ONE,   0, 63,  64,  64));    // already taken
    issue_request(make_req(MODE_RESERVE_RANGE, 5,  9,   0,   0));    // crosses a cell
    issue_request(make_req(MODE_RESERVE_RANGE, 63, 0,   0,   0));    // empty range
    issue_request(make_req(MODE_RESERVE_RANGE, 62, 63,  0,   0));    // partly taken
    issue_request(make_req(MODE_TAKE_RUN,      0,  0,   0,   0));    // run of zero
    issue_request(make_req(MODE_TAKE_RUN,      0,  0,  64,   0));
    issue_request(make_req(MODE_TAKE_RUN,      0,  0, 127,   0));    // above slot count
    issue_request(make_req(MODE_TAKE_RUN,      0,  0,  65,   0));
    issue_request(make_req(MODE_TAKE_RUN,      0,  0,   3,   0));    // skips the gap at 3..4
    issue_request(make_req(MODE_TAKE_RUN,      0,  0,  10,   0));
    issue_request(make_req(MODE_TAKE,          0,  0,   0,   0));
    issue_request(make_req(MODE_UNUSED_6,     21, 42,  33,  17));
    issue_request(make_req(MODE_UNUSED_7,     42, 21,  94, 110));
    issue_request(make_req(MODE_TAKE_BELOW,    0,  0,   0,  64));
    issue_request(make_req(MODE_RESERVE_ONE,  31,  0,   0,   0));
    issue_request(make_req(MODE_TAKE_RUN,      0,  0,   8,   0));
    issue_request(make_req(MODE_QUERY,        63, 63, 127, 127));
  endtask

  task automatic test_random_traffic(input int idle_pct, input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < idle_pct)
        hold_off(($urandom_range(0, 7) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 3));
      issue_request(random_request());
    end
  endtask

  // Fill the whole map; then query, take, take below, reserve one and a run of one or more must find nothing free.
  task automatic test_exhausted_map();
    issue_request(make_req(MODE_RESERVE_RANGE, 0, 63,  0,  0));
    issue_request(make_req(MODE_QUERY,         0,  0,  0,  0));
    issue_request(make_req(MODE_TAKE,          0,  0,  0,  0));
    issue_request(make_req(MODE_TAKE_BELOW,    0,  0,  0, 64));
    issue_request(make_req(MODE_RESERVE_ONE,  17,  0,  0,  0));
    issue_request(make_req(MODE_RESERVE_RANGE, 3,  5,  0,  0));
    issue_request(make_req(MODE_TAKE_RUN,      0,  0,  1,  0));
    issue_request(make_req(MODE_TAKE_RUN,      0,  0,  0,  0));
    issue_request(make_req(MODE_TAKE_RUN,      0,  0, 64,  0));
    issue_request(make_req(MODE_UNUSED_7,      9,  9,  9,  9));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_modes();
    wait_all_done();
    test_random_traffic(0, 500);
    test_random_traffic(56, 500);
    wait_all_done();
    test_random_traffic(23, 500);
    test_exhausted_map();

    wait_all_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
